[rtl/qrmc_pkg.sv]
// ----------------------------------------------------------------------------
// qrmc_pkg: shared definitions for the quad region mean color block
// Widths, sequencer states and the divider request/response structs.
// ----------------------------------------------------------------------------
package qrmc_pkg;

  localparam int COORD_BITS    = 12;
  localparam int CHANNEL_COUNT = 3;
  localparam int ACC_CHANNELS  = (CHANNEL_COUNT < 3) ? CHANNEL_COUNT : 3;
  localparam int CH_W          = 2;
  localparam int COLOR_W       = 8;
  localparam int SUM_W         = 32;
  localparam int TALLY_W       = 25;
  localparam int CFG_IDX_W     = 4;
  localparam int CFG_REG_COUNT = 8;
  localparam int DIFF_W        = COORD_BITS + 1;
  localparam int PROD_W        = 2 * DIFF_W;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BOX,
    ST_LHS,
    ST_RHS,
    ST_CMP,
    ST_ACC,
    ST_DIV,
    ST_DWAIT,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic               start;
    logic [SUM_W-1:0]   dividend;
    logic [TALLY_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] quotient;
  } div_rsp_t;

endpackage

[rtl/qrmc_div.sv]
// ----------------------------------------------------------------------------
// qrmc_div: iterative restoring divider
// One quotient bit per cycle; done pulses in the cycle after the last step.
// ----------------------------------------------------------------------------
module qrmc_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  qrmc_pkg::div_req_t req_i,
  output qrmc_pkg::div_rsp_t rsp_o
);

  localparam int STEP_W = $clog2(qrmc_pkg::SUM_W);

  logic                         busy_q;
  logic                         done_q;
  logic [STEP_W-1:0]            cnt_q;
  logic [qrmc_pkg::SUM_W-1:0]   quo_q;
  logic [qrmc_pkg::TALLY_W-1:0] rem_q;
  logic [qrmc_pkg::TALLY_W-1:0] div_q;
  logic                         last_step;

  logic [qrmc_pkg::TALLY_W:0]   rem_sh;
  logic [qrmc_pkg::TALLY_W+1:0] diff;

  assign last_step = busy_q && (cnt_q == STEP_W'(qrmc_pkg::SUM_W - 1));
  assign rem_sh    = {rem_q, quo_q[qrmc_pkg::SUM_W-1]};
  assign diff      = {1'b0, rem_sh} - {2'b00, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= last_step;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last_step) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      div_q <= req_i.divisor;
    end else if (busy_q) begin
      // keep the trial difference when it does not borrow
      if (!diff[qrmc_pkg::TALLY_W+1]) begin
        rem_q <= diff[qrmc_pkg::TALLY_W-1:0];
        quo_q <= {quo_q[qrmc_pkg::SUM_W-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[qrmc_pkg::TALLY_W-1:0];
        quo_q <= {quo_q[qrmc_pkg::SUM_W-2:0], 1'b0};
      end
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

[rtl/quad_region_mean_color_top.sv]
// ----------------------------------------------------------------------------
// quad_region_mean_color_top: mean color inside a configured quadrilateral
// Pixels inside the vertex bounding box and with odd edge-crossing parity
// add to per-channel sums; the frame's last pixel yields the means.
// ----------------------------------------------------------------------------
//  channel  | handshake             | payload
//  ---------+-----------------------+--------------------------------------
//  cfg      | cfg_valid_i/ready_o   | cfg_index_i, cfg_data_i
//  pixel in | in_valid_i/in_ready_o | pixel_x/y, red/green/blue, frame_last
//  result   | out_valid_o/ready_i   | avg_red/green/blue, inside_count
//
//  A pixel steps through box, then lhs/rhs/cmp for each quadrilateral edge, and
//  acc (box to acc outside the bounding box); the edges share one 13x13
//  signed multiplier. A frame-last pixel then divides each channel in the
//  1-bit-a-cycle divider and loads the result register.
//  Reset clears vertices, sums and tally at once; no clearing pass.
//  A result waiting on out_ready_i holds only the next frame-last pixel.
// ----------------------------------------------------------------------------
module quad_region_mean_color_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [qrmc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [qrmc_pkg::COORD_BITS-1:0]    cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [qrmc_pkg::COORD_BITS-1:0]    pixel_x_i,
  input  logic [qrmc_pkg::COORD_BITS-1:0]    pixel_y_i,
  input  logic [qrmc_pkg::COLOR_W-1:0]       red_i,
  input  logic [qrmc_pkg::COLOR_W-1:0]       green_i,
  input  logic [qrmc_pkg::COLOR_W-1:0]       blue_i,
  input  logic                               frame_last_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [qrmc_pkg::COLOR_W-1:0]       avg_red_o,
  output logic [qrmc_pkg::COLOR_W-1:0]       avg_green_o,
  output logic [qrmc_pkg::COLOR_W-1:0]       avg_blue_o,
  output logic [qrmc_pkg::TALLY_W-1:0]       inside_count_o
);

  localparam int CW = qrmc_pkg::COORD_BITS;
  localparam int DW = qrmc_pkg::DIFF_W;
  localparam int PW = qrmc_pkg::PROD_W;

  qrmc_pkg::state_e state_q, state_d;

  // configured vertices
  logic [CW-1:0] vx_q [4];
  logic [CW-1:0] vy_q [4];

  // working copies, rotated so the current edge is always at slots 0 and 1
  logic [CW-1:0] wx_q [4];
  logic [CW-1:0] wy_q [4];

  logic [CW-1:0]                    px_q, py_q;
  logic [qrmc_pkg::COLOR_W-1:0]     samp_q [3];
  logic                             last_q;
  logic                             box_q;
  logic                             parity_q;
  logic [1:0]                       edge_q;
  logic signed [PW-1:0]             lhs_q, rhs_q;
  logic [qrmc_pkg::SUM_W-1:0]       sums_q [3];
  logic [qrmc_pkg::TALLY_W-1:0]     tally_q;
  logic [qrmc_pkg::CH_W-1:0]        ch_q;
  logic [qrmc_pkg::COLOR_W-1:0]     avg_q [3];

  logic                             out_valid_q;
  logic [qrmc_pkg::COLOR_W-1:0]     out_avg_q [3];
  logic [qrmc_pkg::TALLY_W-1:0]     out_cnt_q;

  logic                             load_out;
  logic                             ch_more;
  qrmc_pkg::div_req_t               div_req;
  qrmc_pkg::div_rsp_t               div_rsp;

  // bounding box
  logic [CW-1:0] xmin01, xmin23, xmin, xmax01, xmax23, xmax;
  logic [CW-1:0] ymin01, ymin23, ymin, ymax01, ymax23, ymax;
  logic          in_box;

  always_comb begin
    xmin01 = (vx_q[1] < vx_q[0]) ? vx_q[1] : vx_q[0];
    xmin23 = (vx_q[3] < vx_q[2]) ? vx_q[3] : vx_q[2];
    xmin   = (xmin23 < xmin01) ? xmin23 : xmin01;
    xmax01 = (vx_q[1] > vx_q[0]) ? vx_q[1] : vx_q[0];
    xmax23 = (vx_q[3] > vx_q[2]) ? vx_q[3] : vx_q[2];
    xmax   = (xmax23 > xmax01) ? xmax23 : xmax01;
    ymin01 = (vy_q[1] < vy_q[0]) ? vy_q[1] : vy_q[0];
    ymin23 = (vy_q[3] < vy_q[2]) ? vy_q[3] : vy_q[2];
    ymin   = (ymin23 < ymin01) ? ymin23 : ymin01;
    ymax01 = (vy_q[1] > vy_q[0]) ? vy_q[1] : vy_q[0];
    ymax23 = (vy_q[3] > vy_q[2]) ? vy_q[3] : vy_q[2];
    ymax   = (ymax23 > ymax01) ? ymax23 : ymax01;
    in_box = (px_q >= xmin) && (px_q < xmax) && (py_q >= ymin) && (py_q < ymax);
  end

  // shared multiplier: lhs = (px-x0)*(y1-y0), rhs = (py-y0)*(x1-x0)
  logic signed [DW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] mul_p;

  always_comb begin
    if (state_q == qrmc_pkg::ST_LHS) begin
      mul_a = $signed({1'b0, px_q}) - $signed({1'b0, wx_q[0]});
      mul_b = $signed({1'b0, wy_q[1]}) - $signed({1'b0, wy_q[0]});
    end else begin
      mul_a = $signed({1'b0, py_q}) - $signed({1'b0, wy_q[0]});
      mul_b = $signed({1'b0, wx_q[1]}) - $signed({1'b0, wx_q[0]});
    end
    mul_p = mul_a * mul_b;
  end

  // edge crossing decision
  logic up, down, rising, crosses;

  always_comb begin
    up      = (wy_q[0] <= py_q) && (wy_q[1] > py_q);
    down    = (wy_q[0] > py_q) && (wy_q[1] <= py_q);
    rising  = wy_q[1] > wy_q[0];
    crosses = (up || down) && (rising ? (lhs_q < rhs_q) : (lhs_q > rhs_q));
  end

  assign ch_more  = ch_q < qrmc_pkg::CH_W'(qrmc_pkg::ACC_CHANNELS);
  assign load_out = (state_q == qrmc_pkg::ST_OUT) && (!out_valid_q || out_ready_i);

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= qrmc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d          = state_q;
    in_ready_o       = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = sums_q[ch_q];
    div_req.divisor  = tally_q;
    case (state_q)
      qrmc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = qrmc_pkg::ST_BOX;
        end
      end
      qrmc_pkg::ST_BOX: begin
        state_d = in_box ? qrmc_pkg::ST_LHS : qrmc_pkg::ST_ACC;
      end
      qrmc_pkg::ST_LHS: begin
        state_d = qrmc_pkg::ST_RHS;
      end
      qrmc_pkg::ST_RHS: begin
        state_d = qrmc_pkg::ST_CMP;
      end
      qrmc_pkg::ST_CMP: begin
        state_d = (edge_q == 2'd3) ? qrmc_pkg::ST_ACC : qrmc_pkg::ST_LHS;
      end
      qrmc_pkg::ST_ACC: begin
        state_d = last_q ? qrmc_pkg::ST_DIV : qrmc_pkg::ST_IDLE;
      end
      qrmc_pkg::ST_DIV: begin
        if ((tally_q == '0) || !ch_more) begin
          state_d = qrmc_pkg::ST_OUT;
        end else begin
          div_req.start = 1'b1;
          state_d       = qrmc_pkg::ST_DWAIT;
        end
      end
      qrmc_pkg::ST_DWAIT: begin
        if (div_rsp.done) begin
          state_d = qrmc_pkg::ST_DIV;
        end
      end
      qrmc_pkg::ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = qrmc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = qrmc_pkg::ST_IDLE;
      end
    endcase
  end

  qrmc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 4; k++) begin
        vx_q[k] <= '0;
        vy_q[k] <= '0;
      end
    end else if (cfg_valid_i &&
                 (cfg_index_i < qrmc_pkg::CFG_IDX_W'(qrmc_pkg::CFG_REG_COUNT))) begin
      if (cfg_index_i[0]) begin
        vy_q[cfg_index_i[2:1]] <= cfg_data_i;
      end else begin
        vx_q[cfg_index_i[2:1]] <= cfg_data_i;
      end
    end
  end

  // per-pixel working registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      qrmc_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          px_q      <= pixel_x_i;
          py_q      <= pixel_y_i;
          samp_q[0] <= red_i;
          samp_q[1] <= green_i;
          samp_q[2] <= blue_i;
          last_q    <= frame_last_i;
        end
      end
      qrmc_pkg::ST_BOX: begin
        box_q    <= in_box;
        parity_q <= 1'b0;
        edge_q   <= '0;
        for (int k = 0; k < 4; k++) begin
          wx_q[k] <= vx_q[k];
          wy_q[k] <= vy_q[k];
        end
      end
      qrmc_pkg::ST_LHS: begin
        lhs_q <= mul_p;
      end
      qrmc_pkg::ST_RHS: begin
        rhs_q <= mul_p;
      end
      qrmc_pkg::ST_CMP: begin
        parity_q <= parity_q ^ crosses;
        edge_q   <= edge_q + 1'b1;
        // advance to the next edge
        for (int k = 0; k < 4; k++) begin
          wx_q[k] <= wx_q[(k + 1) % 4];
          wy_q[k] <= wy_q[(k + 1) % 4];
        end
      end
      qrmc_pkg::ST_ACC: begin
        ch_q <= '0;
        for (int c = 0; c < 3; c++) begin
          avg_q[c] <= '0;
        end
      end
      qrmc_pkg::ST_DWAIT: begin
        if (div_rsp.done) begin
          avg_q[ch_q] <= (|div_rsp.quotient[qrmc_pkg::SUM_W-1:qrmc_pkg::COLOR_W]) ?
                         {qrmc_pkg::COLOR_W{1'b1}} :
                         div_rsp.quotient[qrmc_pkg::COLOR_W-1:0];
          ch_q        <= ch_q + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // frame accumulators, saturating
  logic [qrmc_pkg::SUM_W:0] sum_ext [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum_ext[c] = {1'b0, sums_q[c]} +
                   {{(qrmc_pkg::SUM_W + 1 - qrmc_pkg::COLOR_W){1'b0}}, samp_q[c]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tally_q <= '0;
      for (int c = 0; c < 3; c++) begin
        sums_q[c] <= '0;
      end
    end else if (load_out) begin
      tally_q <= '0;
      for (int c = 0; c < 3; c++) begin
        sums_q[c] <= '0;
      end
    end else if ((state_q == qrmc_pkg::ST_ACC) && box_q && parity_q) begin
      if (tally_q != {qrmc_pkg::TALLY_W{1'b1}}) begin
        tally_q <= tally_q + 1'b1;
      end
      for (int c = 0; c < 3; c++) begin
        if (c < qrmc_pkg::ACC_CHANNELS) begin
          sums_q[c] <= sum_ext[c][qrmc_pkg::SUM_W] ? {qrmc_pkg::SUM_W{1'b1}} :
                       sum_ext[c][qrmc_pkg::SUM_W-1:0];
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      for (int c = 0; c < 3; c++) begin
        out_avg_q[c] <= avg_q[c];
      end
      out_cnt_q <= tally_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign avg_red_o      = out_avg_q[0];
  assign avg_green_o    = out_avg_q[1];
  assign avg_blue_o     = out_avg_q[2];
  assign inside_count_o = out_cnt_q;

  // the divider never sees a zero divisor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> (tally_q != '0))
    else $error("divider started with zero tally");

  // a pixel is taken one at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("ready high right after accept");

  // a pending result is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> (out_valid_q && $stable(out_cnt_q)))
    else $error("pending result lost or changed");

  // frame state clears when the result loads
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> (tally_q == '0) && (sums_q[0] == '0))
    else $error("frame state not cleared after result");

endmodule

[tb/tb_quad_region_mean_color_top.sv]
// ----------------------------------------------------------------------------
// tb_quad_region_mean_color_top: self-checking bench for the quad region mean
// Programs quadrilaterals over the register port, streams frames of pixels
// with random idle on both sides, predicts the per-frame means and pixel
// count from a shadow model and checks every result beat in order.
// ----------------------------------------------------------------------------
module tb_quad_region_mean_color_top;
  import qrmc_pkg::*;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VERTEX0_X, REG_VERTEX0_Y, REG_VERTEX1_X, REG_VERTEX1_Y,
    REG_VERTEX2_X, REG_VERTEX2_Y, REG_VERTEX3_X, REG_VERTEX3_Y
  } cfg_reg_e;

  localparam int COORD_MAX = (1 << COORD_BITS) - 1;
  localparam int COLOR_MAX = (1 << COLOR_W) - 1;

  typedef struct {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COLOR_W-1:0]    color [3];
    logic                  last;
  } pixel_t;

  typedef struct {
    logic [COLOR_W-1:0] avg [3];
    logic [TALLY_W-1:0] count;
  } frame_mean_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [COORD_BITS-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [COORD_BITS-1:0] pixel_x_i = '0;
  logic [COORD_BITS-1:0] pixel_y_i = '0;
  logic [COLOR_W-1:0] red_i = '0;
  logic [COLOR_W-1:0] green_i = '0;
  logic [COLOR_W-1:0] blue_i = '0;
  logic frame_last_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [COLOR_W-1:0] avg_red_o;
  logic [COLOR_W-1:0] avg_green_o;
  logic [COLOR_W-1:0] avg_blue_o;
  logic [TALLY_W-1:0] inside_count_o;

  quad_region_mean_color_top i_dut (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .pixel_x_i, .pixel_y_i,
    .red_i, .green_i, .blue_i, .frame_last_i,
    .out_valid_o, .out_ready_i,
    .avg_red_o, .avg_green_o, .avg_blue_o, .inside_count_o
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // shadow of the vertices and the running frame sums
  logic [COORD_BITS-1:0] quad_vx [4];
  logic [COORD_BITS-1:0] quad_vy [4];
  logic [SUM_W-1:0]      chan_sum [3];
  logic [TALLY_W-1:0]    tally;

  pixel_t      pixel_q [$];
  frame_mean_t mean_q [$];

  int  bad_results = 0;
  bit  pix_taken = 1'b0;
  bit  sender_gaps_on = 1'b0;
  bit  receiver_stalls_on = 1'b0;
  bit  hold_request = 1'b0;
  bit  hold_done = 1'b0;
  int  hold_cnt = 0;
  int  send_gap = 0;
  int  recv_gap = 0;

  initial begin
    for (int k = 0; k < 4; k++) begin
      quad_vx[k] = '0;
      quad_vy[k] = '0;
    end
    for (int c = 0; c < 3; c++) chan_sum[c] = '0;
    tally = '0;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(20, 60);
  endfunction

  // crossing-number test against the shadow quadrilateral
  function automatic bit pixel_in_quad(logic [COORD_BITS-1:0] px_u,
                                       logic [COORD_BITS-1:0] py_u);
    longint px, py, xmin, xmax, ymin, ymax;
    longint x0, y0, x1, y1, dy, lhs, rhs;
    int n;
    int crossings;
    bit up, down;
    px = longint'(px_u);
    py = longint'(py_u);
    xmin = longint'(quad_vx[0]); xmax = longint'(quad_vx[0]);
    ymin = longint'(quad_vy[0]); ymax = longint'(quad_vy[0]);
    crossings = 0;
    for (int k = 1; k < 4; k++) begin
      if (longint'(quad_vx[k]) < xmin) xmin = longint'(quad_vx[k]);
      if (longint'(quad_vx[k]) > xmax) xmax = longint'(quad_vx[k]);
      if (longint'(quad_vy[k]) < ymin) ymin = longint'(quad_vy[k]);
      if (longint'(quad_vy[k]) > ymax) ymax = longint'(quad_vy[k]);
    end
    if (px < xmin || px >= xmax || py < ymin || py >= ymax) return 1'b0;
    for (int k = 0; k < 4; k++) begin
      n = (k + 1) % 4;
      x0 = longint'(quad_vx[k]); y0 = longint'(quad_vy[k]);
      x1 = longint'(quad_vx[n]); y1 = longint'(quad_vy[n]);
      up = (y0 <= py) && (y1 > py);
      down = (y0 > py) && (y1 <= py);
      if (up || down) begin
        dy = y1 - y0;
        lhs = (px - x0) * dy;
        rhs = (py - y0) * (x1 - x0);
        if (dy > 0 ? (lhs < rhs) : (lhs > rhs)) crossings++;
      end
    end
    return crossings[0];
  endfunction

  // fold one accepted pixel into the frame; close the frame on its last pixel
  function automatic void accumulate_pixel(pixel_t p);
    frame_mean_t m;
    longint unsigned s, q;
    if (pixel_in_quad(p.x, p.y)) begin
      if (tally != {TALLY_W{1'b1}}) tally = tally + 1'b1;
      for (int c = 0; c < ACC_CHANNELS; c++) begin
        s = longint'(chan_sum[c]) + longint'(p.color[c]);
        chan_sum[c] = (s > 64'hFFFF_FFFF) ? {SUM_W{1'b1}} : s[SUM_W-1:0];
      end
    end
    if (p.last) begin
      for (int c = 0; c < 3; c++) begin
        m.avg[c] = '0;
        if (tally != 0 && c < CHANNEL_COUNT) begin
          q = longint'(chan_sum[c]) / longint'(tally);
          m.avg[c] = (q > COLOR_MAX) ? COLOR_MAX[COLOR_W-1:0] : q[COLOR_W-1:0];
        end
      end
      m.count = tally;
      mean_q.insert(mean_q.size(), m);
      for (int c = 0; c < 3; c++) chan_sum[c] = '0;
      tally = '0;
    end
  endfunction

  task automatic report_field(string field, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
      bad_results++;
    end
  endtask

  // sample both channels on the rising edge
  always @(posedge clk_i) begin : watch_beats
    frame_mean_t m;
    pixel_t p;
    pix_taken <= in_valid_i && in_ready_o;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (mean_q.size() == 0) begin
        $display("%0t: unexpected result expected none actual %0d %0d %0d count %0d",
                 $time, avg_red_o, avg_green_o, avg_blue_o, inside_count_o);
        bad_results++;
      end else begin
        m = mean_q.pop_front();
        report_field("avg_red", 64'(m.avg[0]), 64'(avg_red_o));
        report_field("avg_green", 64'(m.avg[1]), 64'(avg_green_o));
        report_field("avg_blue", 64'(m.avg[2]), 64'(avg_blue_o));
        report_field("inside_count", 64'(m.count), 64'(inside_count_o));
      end
    end
    if (rst_ni && in_valid_i && in_ready_o) begin
      p.x = pixel_x_i;
      p.y = pixel_y_i;
      p.color[0] = red_i;
      p.color[1] = green_i;
      p.color[2] = blue_i;
      p.last = frame_last_i;
      accumulate_pixel(p);
    end
  end

  // pixel sender: hold the beat until taken, then idle or advance
  always @(negedge clk_i) begin : drive_pixels
    pixel_t p;
    if (rst_ni && !(in_valid_i && !pix_taken)) begin
      if (send_gap > 0) begin
        in_valid_i <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pixel_q.size() != 0) begin
        p = pixel_q.pop_front();
        pixel_x_i <= p.x;
        pixel_y_i <= p.y;
        red_i <= p.color[0];
        green_i <= p.color[1];
        blue_i <= p.color[2];
        frame_last_i <= p.last;
        in_valid_i <= 1'b1;
        send_gap <= sender_gaps_on ? idle_len() : 0;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result receiver, with one long hold-off on request
  always @(negedge clk_i) begin : drive_ready
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_cnt > 0) begin
      out_ready_i <= 1'b0;
      hold_cnt <= hold_cnt - 1;
    end else if (hold_request && !hold_done) begin
      out_ready_i <= 1'b0;
      hold_cnt <= 1500;
      hold_done <= 1'b1;
    end else if (recv_gap > 0) begin
      out_ready_i <= 1'b0;
      recv_gap <= recv_gap - 1;
    end else begin
      out_ready_i <= 1'b1;
      recv_gap <= receiver_stalls_on ? idle_len() : 0;
    end
  end

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [COORD_BITS-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_VERTEX0_X: quad_vx[0] = data;
      REG_VERTEX0_Y: quad_vy[0] = data;
      REG_VERTEX1_X: quad_vx[1] = data;
      REG_VERTEX1_Y: quad_vy[1] = data;
      REG_VERTEX2_X: quad_vx[2] = data;
      REG_VERTEX2_Y: quad_vy[2] = data;
      REG_VERTEX3_X: quad_vx[3] = data;
      REG_VERTEX3_Y: quad_vy[3] = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic bad_index_write();
    cfg_write(CFG_IDX_W'($urandom_range((1 << CFG_IDX_W) - 1, CFG_REG_COUNT)),
              COORD_BITS'($urandom_range(0, COORD_MAX)));
  endtask

  task automatic set_quad(int x0, int y0, int x1, int y1, int x2, int y2, int x3, int y3);
    cfg_write(REG_VERTEX0_X, COORD_BITS'(x0));
    cfg_write(REG_VERTEX0_Y, COORD_BITS'(y0));
    cfg_write(REG_VERTEX1_X, COORD_BITS'(x1));
    cfg_write(REG_VERTEX1_Y, COORD_BITS'(y1));
    cfg_write(REG_VERTEX2_X, COORD_BITS'(x2));
    cfg_write(REG_VERTEX2_Y, COORD_BITS'(y2));
    cfg_write(REG_VERTEX3_X, COORD_BITS'(x3));
    cfg_write(REG_VERTEX3_Y, COORD_BITS'(y3));
  endtask

  task automatic queue_pixel(int x, int y, int r, int g, int b, bit last);
    pixel_t p;
    p.x = COORD_BITS'(x);
    p.y = COORD_BITS'(y);
    p.color[0] = COLOR_W'(r);
    p.color[1] = COLOR_W'(g);
    p.color[2] = COLOR_W'(b);
    p.last = last;
    pixel_q.insert(pixel_q.size(), p);
  endtask

  function automatic int random_color();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 1) return COLOR_MAX;
    return $urandom_range(0, COLOR_MAX);
  endfunction

  function automatic int clamp_coord(int v);
    if (v < 0) return 0;
    if (v > COORD_MAX) return COORD_MAX;
    return v;
  endfunction

  task automatic random_quad(int mode);
    int xs [4];
    int ys [4];
    int cx, cy, rad;
    cx = $urandom_range(0, COORD_MAX);
    cy = $urandom_range(0, COORD_MAX);
    rad = (mode == 4) ? $urandom_range(41, 300) : $urandom_range(1, 40);
    for (int k = 0; k < 4; k++) begin
      case (mode)
        1: begin
          xs[k] = $urandom_range(0, COORD_MAX);
          ys[k] = $urandom_range(0, COORD_MAX);
        end
        2: begin
          xs[k] = $urandom_range(0, 1) ? COORD_MAX : 0;
          ys[k] = $urandom_range(0, 1) ? COORD_MAX : 0;
        end
        default: begin
          xs[k] = clamp_coord(cx + $urandom_range(0, 2 * rad) - rad);
          ys[k] = clamp_coord(cy + $urandom_range(0, 2 * rad) - rad);
        end
      endcase
    end
    if (mode == 3) begin
      // collapse the box, or repeat a vertex next to a flat edge
      case ($urandom_range(0, 2))
        0: for (int k = 1; k < 4; k++) ys[k] = ys[0];
        1: for (int k = 1; k < 4; k++) xs[k] = xs[0];
        default: begin
          xs[2] = xs[1];
          ys[2] = ys[1];
          ys[3] = ys[0];
        end
      endcase
    end
    if ($urandom_range(0, 1)) bad_index_write();
    set_quad(xs[0], ys[0], xs[1], ys[1], xs[2], ys[2], xs[3], ys[3]);
    if ($urandom_range(0, 1)) bad_index_write();
  endtask

  // frames of random length, most pixels aimed at the vertex box
  task automatic random_frames(int n_items);
    int xmin, xmax, ymin, ymax, len, added, x, y;
    xmin = int'(quad_vx[0]); xmax = int'(quad_vx[0]);
    ymin = int'(quad_vy[0]); ymax = int'(quad_vy[0]);
    for (int k = 1; k < 4; k++) begin
      if (int'(quad_vx[k]) < xmin) xmin = int'(quad_vx[k]);
      if (int'(quad_vx[k]) > xmax) xmax = int'(quad_vx[k]);
      if (int'(quad_vy[k]) < ymin) ymin = int'(quad_vy[k]);
      if (int'(quad_vy[k]) > ymax) ymax = int'(quad_vy[k]);
    end
    added = 0;
    while (added < n_items) begin
      len = $urandom_range(0, 4) == 0 ? 1 : $urandom_range(2, 20);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 99) < 80) begin
          x = $urandom_range(clamp_coord(xmin - 2), clamp_coord(xmax + 1));
          y = $urandom_range(clamp_coord(ymin - 2), clamp_coord(ymax + 1));
        end else begin
          x = $urandom_range(0, COORD_MAX);
          y = $urandom_range(0, COORD_MAX);
        end
        queue_pixel(x, y, random_color(), random_color(), random_color(), i == len - 1);
      end
      added += len;
    end
  endtask

  task automatic settle_phase();
    while (pixel_q.size() != 0 || in_valid_i || mean_q.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // reset vertices: empty box, every frame reports zeros
    queue_pixel(0, 0, 200, 100, 50, 1'b1);
    queue_pixel(COORD_MAX, COORD_MAX, COLOR_MAX, COLOR_MAX, COLOR_MAX, 1'b1);
    settle_phase();

    // full-range square: the max column and row fall outside the half-open box
    sender_gaps_on = 1'b1;
    receiver_stalls_on = 1'b1;
    set_quad(0, 0, COORD_MAX, 0, COORD_MAX, COORD_MAX, 0, COORD_MAX);
    queue_pixel(0, 0, COLOR_MAX, 0, 128, 1'b0);
    queue_pixel(COORD_MAX - 1, COORD_MAX - 1, COLOR_MAX, COLOR_MAX, COLOR_MAX, 1'b0);
    queue_pixel(COORD_MAX, 100, COLOR_MAX, COLOR_MAX, COLOR_MAX, 1'b0);
    queue_pixel(100, COORD_MAX, COLOR_MAX, COLOR_MAX, COLOR_MAX, 1'b0);
    queue_pixel(2048, 2048, 0, 0, 0, 1'b0);
    queue_pixel(2048, 2048, 0, 0, 0, 1'b0);
    queue_pixel(1, 1, 7, 9, 13, 1'b1);
    queue_pixel(COORD_MAX, COORD_MAX, 1, 2, 3, 1'b1);
    settle_phase();

    // crossed quad with two flat edges
    set_quad(10, 10, 50, 10, 10, 50, 50, 50);
    queue_pixel(12, 11, 10, 20, 30, 1'b0);
    queue_pixel(30, 20, 40, 50, 60, 1'b0);
    queue_pixel(20, 30, 70, 80, 90, 1'b0);
    queue_pixel(48, 12, 100, 110, 120, 1'b0);
    queue_pixel(30, 45, 130, 140, 150, 1'b1);
    settle_phase();

    // zero-width box, then out-of-range indexes that must not land
    set_quad(100, 0, 100, COORD_MAX, 100, 300, 100, 20);
    cfg_write(CFG_IDX_W'(CFG_REG_COUNT), COORD_BITS'(COORD_MAX));
    cfg_write(CFG_IDX_W'((1 << CFG_IDX_W) - 1), COORD_BITS'(COORD_MAX));
    queue_pixel(100, 100, 50, 50, 50, 1'b1);
    queue_pixel(99, 100, 50, 50, 50, 1'b1);
    settle_phase();

    for (int p = 0; p < 9; p++) begin
      sender_gaps_on = (p % 3 != 0);
      receiver_stalls_on = (p % 4 != 1);
      random_quad(p % 5);
      random_frames(78);
      if (p == 4) hold_request = 1'b1;
      settle_phase();
    end

    repeat (200) @(posedge clk_i);
    if (bad_results == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
